>>> hw/rtl/u16u8_pkg.sv
// Shared types, constants and the code point encoder of the UTF-16 to UTF-8 encoder.
// Used by every module of the block; depends on nothing.
`default_nettype none

package u16u8_pkg;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
    localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
    localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
    localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [20:0] ONE_BYTE_LIM  = 21'h80;
    localparam logic [20:0] TWO_BYTE_LIM  = 21'h800;
    localparam logic [7:0]  LEAD_TWO      = 8'hC0;
    localparam logic [7:0]  LEAD_THREE    = 8'hE0;
    localparam logic [7:0]  LEAD_FOUR     = 8'hF0;
    localparam logic [7:0]  CONT_MARK     = 8'h80;

    typedef struct packed {
        logic [3:0][7:0] bytes;
        logic [2:0]      len;
    } enc_t;

    typedef struct packed {
        logic [5:0][7:0] bytes;
        logic [2:0]      len;
        logic            last;
    } job_t;

    typedef struct packed {
        logic full;
        logic head_valid;
    } q_status_t;

    function automatic enc_t encode_cp(input logic [20:0] cp);
        enc_t e;
        e = '0;
        if (cp < ONE_BYTE_LIM) begin
            e.bytes[0] = cp[7:0];
            e.len      = 3'd1;
        end
        else if (cp < TWO_BYTE_LIM) begin
            e.bytes[0] = LEAD_TWO | {3'b000, cp[10:6]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[5:0]};
            e.len      = 3'd2;
        end
        else if (cp < SUPP_BASE) begin
            e.bytes[0] = LEAD_THREE | {4'b0000, cp[15:12]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[11:6]};
            e.bytes[2] = CONT_MARK | {2'b00, cp[5:0]};
            e.len      = 3'd3;
        end
        else begin
            e.bytes[0] = LEAD_FOUR | {5'b00000, cp[20:18]};
            e.bytes[1] = CONT_MARK | {2'b00, cp[17:12]};
            e.bytes[2] = CONT_MARK | {2'b00, cp[11:6]};
            e.bytes[3] = CONT_MARK | {2'b00, cp[5:0]};
            e.len      = 3'd4;
        end
        return e;
    endfunction

endpackage

`default_nettype wire

>>> hw/rtl/utf16_to_utf8_encoder_core.sv
// UTF-16 to UTF-8 encoder: takes one code unit per item and sends UTF-8 bytes, one
// byte per item on the output side. A code unit is accepted in every cycle while the
// job queue (QUEUE_DEPTH entries) has room, and its bytes pass through a queue entry
// and the output register. The output sends one byte per cycle while byte_stall is
// low. A code unit causes no bytes when it is a held high surrogate, one to three
// for a plain unit, four for a surrogate pair and up to six when a held high surrogate
// is flushed ahead of the new unit. The single byte lane of the serializer sets the
// sustained rate. last_of_run marks the last byte caused by one code unit, and
// string_end the last byte of a string. Depends on u16u8_pkg and the three parts below.
`default_nettype none

module utf16_to_utf8_encoder_core
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        unit_valid,
    output logic             unit_stall,
    input  wire logic [15:0] code_unit,
    input  wire logic        last_unit,
    output logic             byte_valid,
    input  wire logic        byte_stall,
    output logic [7:0]       out_byte,
    output logic             last_of_run,
    output logic             string_end
);

    q_status_t q_status;
    logic      push;
    job_t      push_job;
    logic      pop;
    job_t      head_job;

    u16u8_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .code_unit  (code_unit),
        .last_unit  (last_unit),
        .q_status   (q_status),
        .push       (push),
        .push_job   (push_job)
    );

    u16u8_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .q_status (q_status),
        .head_job (head_job)
    );

    u16u8_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_status    (q_status),
        .head_job    (head_job),
        .pop         (pop),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .out_byte    (out_byte),
        .last_of_run (last_of_run),
        .string_end  (string_end)
    );

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n) !(push && q_status.full))
        else $error("Job pushed into a full queue.");

    assert property (@(posedge clk) disable iff (!rst_n) pop |-> q_status.head_valid)
        else $error("Job popped from an empty queue.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> q_status.head_valid)
        else $error("Queue empty after a job was pushed.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (byte_valid && string_end) |-> last_of_run)
        else $error("String end flagged on a byte that does not close its run.");
`endif

endmodule

`default_nettype wire

>>> hw/rtl/u16u8_front.sv
// Front end: accepts code units, pairs surrogates and builds a byte job for each unit that yields bytes.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_front
    import u16u8_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        unit_valid,
    output logic             unit_stall,
    input  wire logic [15:0] code_unit,
    input  wire logic        last_unit,
    input  wire q_status_t   q_status,
    output logic             push,
    output job_t             push_job
);

    logic        held_valid_reg;
    logic        held_valid_next;
    logic [15:0] held_unit_reg;
    logic [15:0] held_unit_next;

    logic        accept;
    logic        is_high;
    logic        is_low;
    logic        hold_unit;
    logic [20:0] pair_cp;
    enc_t        enc_unit;
    enc_t        enc_held;
    enc_t        enc_pair;

    always_comb
    begin
        accept    = unit_valid && !q_status.full;
        is_high   = code_unit inside {[HIGH_SURR_MIN:HIGH_SURR_MAX]};
        is_low    = code_unit inside {[LOW_SURR_MIN:LOW_SURR_MAX]};
        hold_unit = is_high && !last_unit;
        pair_cp   = {1'b0, held_unit_reg[9:0], code_unit[9:0]} + SUPP_BASE;
        enc_unit  = encode_cp({5'b00000, code_unit});
        enc_held  = encode_cp({5'b00000, held_unit_reg});
        enc_pair  = encode_cp(pair_cp);

        push_job      = '0;
        push_job.last = last_unit;
        if (held_valid_reg && is_low) begin
            push_job.bytes[3:0] = enc_pair.bytes;
            push_job.len        = enc_pair.len;
        end
        else if (held_valid_reg) begin
            push_job.bytes[2:0] = enc_held.bytes[2:0];
            push_job.bytes[5:3] = enc_unit.bytes[2:0];
            push_job.len        = hold_unit ? 3'd3 : 3'd3 + enc_unit.len;
        end
        else begin
            push_job.bytes[3:0] = enc_unit.bytes;
            push_job.len        = hold_unit ? 3'd0 : enc_unit.len;
        end

        push            = accept && (push_job.len != 3'd0);
        held_valid_next = held_valid_reg;
        held_unit_next  = held_unit_reg;
        if (accept) begin
            if (held_valid_reg && is_low) begin
                held_valid_next = 1'b0;
            end
            else begin
                held_valid_next = hold_unit;
                held_unit_next  = code_unit;
            end
        end
        unit_stall = q_status.full;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_valid_reg <= 1'b0;
        end
        else begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_unit_reg <= held_unit_next;
    end

endmodule

`default_nettype wire

>>> hw/rtl/u16u8_queue.sv
// Short job queue that decouples the front end from the byte serializer.
// Depends on u16u8_pkg.
`default_nettype none

module u16u8_queue
    import u16u8_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire job_t  push_job,
    input  wire logic  pop,
    output q_status_t  q_status,
    output job_t       head_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR  = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(QUEUE_DEPTH);

    job_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
        q_status.full       = (count_reg == DEPTH_CNT);
        q_status.head_valid = (count_reg != '0);
        head_job            = entry_reg[rd_ptr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/u16u8_back.sv
// Back end: sends the bytes of the job at the queue head one per cycle while byte_stall
// is low, through an output register. Depends on u16u8_pkg.
`default_nettype none

module u16u8_back
    import u16u8_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire q_status_t  q_status,
    input  wire job_t       head_job,
    output logic            pop,
    output logic            byte_valid,
    input  wire logic       byte_stall,
    output logic [7:0]      out_byte,
    output logic            last_of_run,
    output logic            string_end
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       run_end_reg;
    logic       run_end_next;
    logic       str_end_reg;
    logic       str_end_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;

    logic       can_load;
    logic       at_end;

    always_comb
    begin
        can_load     = !valid_reg || !byte_stall;
        at_end       = (idx_reg == head_job.len - 3'd1);
        pop          = can_load && q_status.head_valid && at_end;
        valid_next   = valid_reg;
        byte_next    = byte_reg;
        run_end_next = run_end_reg;
        str_end_next = str_end_reg;
        idx_next     = idx_reg;
        if (can_load) begin
            valid_next   = q_status.head_valid;
            byte_next    = head_job.bytes[idx_reg];
            run_end_next = at_end;
            str_end_next = at_end && head_job.last;
            if (q_status.head_valid) begin
                idx_next = at_end ? 3'd0 : idx_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg    <= byte_next;
        run_end_reg <= run_end_next;
        str_end_reg <= str_end_next;
    end

    assign byte_valid  = valid_reg;
    assign out_byte    = byte_reg;
    assign last_of_run = run_end_reg;
    assign string_end  = str_end_reg;

endmodule

`default_nettype wire

>>> sim/tb_top.sv
// Self-checking testbench of utf16_to_utf8_encoder_core: directed and random UTF-16 strings
// with random idling on both sides, each byte checked against an in-bench UTF-8 encoder.
// Depends only on the RTL of the block.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] SURR_HIGH_FIRST    = 16'hD800;
    localparam logic [15:0] SURR_HIGH_LAST     = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_FIRST     = 16'hDC00;
    localparam logic [15:0] SURR_LOW_LAST      = 16'hDFFF;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h10000;
    localparam logic [20:0] ONE_BYTE_LIMIT     = 21'h80;
    localparam logic [20:0] TWO_BYTE_LIMIT     = 21'h800;
    localparam logic [7:0]  LEAD_OF_TWO        = 8'hC0;
    localparam logic [7:0]  LEAD_OF_THREE      = 8'hE0;
    localparam logic [7:0]  LEAD_OF_FOUR       = 8'hF0;
    localparam logic [7:0]  CONT_PREFIX        = 8'h80;
    localparam logic [7:0]  CONT_BITS          = 8'h3F;
    localparam int          HOLD_OFF_CYCLES    = 250;
    localparam int          SETTLE_CYCLES      = 12;

    typedef struct {
        logic [7:0] data;
        logic       run_end;
        logic       str_end;
    } utf8_byte_t;

    logic        clk;
    logic        rst_n      = 1'b0;
    logic        unit_valid = 1'b0;
    logic        unit_stall;
    logic [15:0] code_unit  = 16'h0000;
    logic        last_unit  = 1'b0;
    logic        byte_valid;
    logic        byte_stall = 1'b0;
    logic [7:0]  out_byte;
    logic        last_of_run;
    logic        string_end;

    utf8_byte_t  expected_bytes[$];
    logic [7:0]  byte_seq[$];
    logic [15:0] pending_high  = 16'h0000;
    logic        pending_valid = 1'b0;
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_count    = 0;
    logic        hold_request  = 1'b0;

    utf16_to_utf8_encoder_core dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .unit_valid (unit_valid),
        .unit_stall (unit_stall),
        .code_unit  (code_unit),
        .last_unit  (last_unit),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .out_byte   (out_byte),
        .last_of_run(last_of_run),
        .string_end (string_end)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void add_byte(input logic [7:0] b);
        byte_seq.insert(byte_seq.size(), b);
    endfunction

    function automatic void append_utf8(input logic [20:0] cp);
        if (cp < ONE_BYTE_LIMIT)
        begin
            add_byte(cp[7:0]);
        end
        else if (cp < TWO_BYTE_LIMIT)
        begin
            add_byte(LEAD_OF_TWO | {3'b000, cp[10:6]});
            add_byte(CONT_PREFIX | (cp[7:0] & CONT_BITS));
        end
        else if (cp < SUPPLEMENTARY_BASE)
        begin
            add_byte(LEAD_OF_THREE | {4'b0000, cp[15:12]});
            add_byte(CONT_PREFIX | ({2'b00, cp[11:6]} & CONT_BITS));
            add_byte(CONT_PREFIX | (cp[7:0] & CONT_BITS));
        end
        else
        begin
            add_byte(LEAD_OF_FOUR | {5'b00000, cp[20:18]});
            add_byte(CONT_PREFIX | ({2'b00, cp[17:12]} & CONT_BITS));
            add_byte(CONT_PREFIX | ({2'b00, cp[11:6]} & CONT_BITS));
            add_byte(CONT_PREFIX | (cp[7:0] & CONT_BITS));
        end
    endfunction

    function automatic void predict_utf8_bytes(input logic [15:0] unit, input logic last);
        logic       is_high;
        logic       is_low;
        logic [20:0] cp;
        utf8_byte_t entry;
        is_high = (unit >= SURR_HIGH_FIRST) && (unit <= SURR_HIGH_LAST);
        is_low  = (unit >= SURR_LOW_FIRST) && (unit <= SURR_LOW_LAST);
        byte_seq.delete();
        if (pending_valid && is_low)
        begin
            cp = ({5'd0, pending_high - SURR_HIGH_FIRST} << 10)
                 + {5'd0, unit - SURR_LOW_FIRST} + SUPPLEMENTARY_BASE;
            append_utf8(cp);
            pending_valid = 1'b0;
            pending_high  = 16'h0000;
        end
        else
        begin
            if (pending_valid)
            begin
                append_utf8({5'd0, pending_high});
                pending_valid = 1'b0;
                pending_high  = 16'h0000;
            end
            if (is_high && !last)
            begin
                pending_high  = unit;
                pending_valid = 1'b1;
            end
            else
            begin
                append_utf8({5'd0, unit});
            end
        end
        foreach (byte_seq[i])
        begin
            entry.data    = byte_seq[i];
            entry.run_end = (i == byte_seq.size() - 1);
            entry.str_end = entry.run_end && last;
            expected_bytes.insert(expected_bytes.size(), entry);
        end
    endfunction

    task automatic send_unit(input logic [15:0] unit, input logic last);
        if ($urandom_range(99) < send_idle_pct)
        begin
            unit_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        unit_valid <= 1'b1;
        code_unit  <= unit;
        last_unit  <= last;
        do
            @(posedge clk);
        while (unit_stall);
        predict_utf8_bytes(unit, last);
    endtask

    task automatic drain_outputs();
        unit_valid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (hold_request)
        begin
            hold_count   = HOLD_OFF_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_count > 0)
        begin
            hold_count = hold_count - 1;
            byte_stall <= 1'b1;
        end
        else
        begin
            byte_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        utf8_byte_t want;
        if (rst_n && byte_valid && !byte_stall)
        begin
            if (expected_bytes.size() == 0)
            begin
                $error("out_byte: no byte expected, got %02h", out_byte);
                error_count++;
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (out_byte !== want.data)
                begin
                    $error("out_byte: expected %02h, got %02h", want.data, out_byte);
                    error_count++;
                end
                if (last_of_run !== want.run_end)
                begin
                    $error("last_of_run: expected %0b, got %0b", want.run_end, last_of_run);
                    error_count++;
                end
                if (string_end !== want.str_end)
                begin
                    $error("string_end: expected %0b, got %0b", want.str_end, string_end);
                    error_count++;
                end
            end
        end
    end

    task automatic test_known_sequences();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_unit(16'h0000, 1'b0);
        send_unit(16'h007F, 1'b0);
        send_unit(16'h0080, 1'b0);
        send_unit(16'h07FF, 1'b0);
        send_unit(16'h0800, 1'b0);
        send_unit(16'hD7FF, 1'b0);
        send_unit(16'hE000, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        send_unit(SURR_HIGH_FIRST, 1'b0);
        send_unit(SURR_LOW_FIRST, 1'b0);
        send_unit(SURR_HIGH_LAST, 1'b0);
        send_unit(SURR_LOW_LAST, 1'b1);
        send_unit(16'hD83D, 1'b0);
        send_unit(16'h0041, 1'b0);
        send_unit(SURR_HIGH_FIRST, 1'b0);
        send_unit(SURR_HIGH_LAST, 1'b0);
        send_unit(16'hFFFF, 1'b1);
        send_unit(16'hDABC, 1'b1);
        send_unit(SURR_LOW_FIRST, 1'b0);
        send_unit(SURR_LOW_LAST, 1'b0);
        send_unit(16'hD9A5, 1'b0);
        send_unit(16'hDE01, 1'b1);
        send_unit(16'h5A5A, 1'b1);
        drain_outputs();
    endtask

    task automatic test_random_text(input int n_units, input int idle_pct, input int stall_pct);
        logic [15:0] units[$];
        int          sent;
        int          len;
        int          pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_units)
        begin
            units.delete();
            len = $urandom_range(1, 8);
            while (units.size() < len)
            begin
                pick = $urandom_range(99);
                if (pick < 22)
                    units.insert(units.size(), 16'($urandom_range(16'h007F)));
                else if (pick < 36)
                    units.insert(units.size(), 16'($urandom_range(16'h07FF, 16'h0080)));
                else if (pick < 44)
                    units.insert(units.size(), 16'($urandom_range(16'hD7FF, 16'h0800)));
                else if (pick < 50)
                    units.insert(units.size(), 16'($urandom_range(16'hFFFF, 16'hE000)));
                else if (pick < 76)
                begin
                    units.insert(units.size(),
                                 16'($urandom_range(SURR_HIGH_LAST, SURR_HIGH_FIRST)));
                    units.insert(units.size(),
                                 16'($urandom_range(SURR_LOW_LAST, SURR_LOW_FIRST)));
                end
                else if (pick < 85)
                    units.insert(units.size(),
                                 16'($urandom_range(SURR_HIGH_LAST, SURR_HIGH_FIRST)));
                else if (pick < 91)
                    units.insert(units.size(),
                                 16'($urandom_range(SURR_LOW_LAST, SURR_LOW_FIRST)));
                else
                    units.insert(units.size(), 16'($urandom));
            end
            foreach (units[i])
                send_unit(units[i], i == units.size() - 1);
            sent += units.size();
        end
        drain_outputs();
    endtask

    task automatic test_output_hold_off();
        logic [15:0] unit;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_request   = 1'b1;
        for (int i = 0; i < 40; i++)
        begin
            if (i % 3 == 0)
                unit = 16'($urandom_range(16'hFFFF, 16'hE000));
            else if (i % 3 == 1)
                unit = 16'($urandom_range(SURR_HIGH_LAST, SURR_HIGH_FIRST));
            else
                unit = 16'($urandom_range(16'h07FF, 16'h0080));
            send_unit(unit, i == 39);
        end
        drain_outputs();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_known_sequences();
        test_random_text(90, 0, 0);
        test_random_text(70, 75, 0);
        test_random_text(70, 0, 75);
        test_random_text(70, 25, 25);
        test_output_hold_off();
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hw/rtl/u16u8_pkg.sv
hw/rtl/u16u8_front.sv
hw/rtl/u16u8_queue.sv
hw/rtl/u16u8_back.sv
hw/rtl/utf16_to_utf8_encoder_core.sv
sim/tb_top.sv
